// ===== hw/rtl/bct_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bct_pkg
// Shared types, constants and the step table for the curve tessellator.
// ----------------------------------------------------------------------------
package bct_pkg;

    localparam int unsigned MaxSegments = 64;
    localparam int unsigned CoordWidth  = 16;
    localparam logic [CoordWidth-1:0] CoordBias = 16'h8000;
    localparam logic [6:0] SegCountReset = 7'd16;

    typedef struct packed {
        logic                        cubic;
        logic [6:0]                  seg_n;
        logic [3:0][CoordWidth-1:0]  px;
        logic [3:0][CoordWidth-1:0]  py;
        logic [31:0]                 rgba;
    } t_curve;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_EMIT
    } t_back_state;

    // {65536 / n, 65536 % n}; the quotient for one segment is never used
    function automatic logic [22:0] step_frac(input logic [6:0] n);
        logic [22:0] r;
        case (n)
            7'd2:  r = {16'd32768, 7'd0};
            7'd3:  r = {16'd21845, 7'd1};
            7'd4:  r = {16'd16384, 7'd0};
            7'd5:  r = {16'd13107, 7'd1};
            7'd6:  r = {16'd10922, 7'd4};
            7'd7:  r = {16'd9362,  7'd2};
            7'd8:  r = {16'd8192,  7'd0};
            7'd9:  r = {16'd7281,  7'd7};
            7'd10: r = {16'd6553,  7'd6};
            7'd11: r = {16'd5957,  7'd9};
            7'd12: r = {16'd5461,  7'd4};
            7'd13: r = {16'd5041,  7'd3};
            7'd14: r = {16'd4681,  7'd2};
            7'd15: r = {16'd4369,  7'd1};
            7'd16: r = {16'd4096,  7'd0};
            7'd17: r = {16'd3855,  7'd1};
            7'd18: r = {16'd3640,  7'd16};
            7'd19: r = {16'd3449,  7'd5};
            7'd20: r = {16'd3276,  7'd16};
            7'd21: r = {16'd3120,  7'd16};
            7'd22: r = {16'd2978,  7'd20};
            7'd23: r = {16'd2849,  7'd9};
            7'd24: r = {16'd2730,  7'd16};
            7'd25: r = {16'd2621,  7'd11};
            7'd26: r = {16'd2520,  7'd16};
            7'd27: r = {16'd2427,  7'd7};
            7'd28: r = {16'd2340,  7'd16};
            7'd29: r = {16'd2259,  7'd25};
            7'd30: r = {16'd2184,  7'd16};
            7'd31: r = {16'd2114,  7'd2};
            7'd32: r = {16'd2048,  7'd0};
            7'd33: r = {16'd1985,  7'd31};
            7'd34: r = {16'd1927,  7'd18};
            7'd35: r = {16'd1872,  7'd16};
            7'd36: r = {16'd1820,  7'd16};
            7'd37: r = {16'd1771,  7'd9};
            7'd38: r = {16'd1724,  7'd24};
            7'd39: r = {16'd1680,  7'd16};
            7'd40: r = {16'd1638,  7'd16};
            7'd41: r = {16'd1598,  7'd18};
            7'd42: r = {16'd1560,  7'd16};
            7'd43: r = {16'd1524,  7'd4};
            7'd44: r = {16'd1489,  7'd20};
            7'd45: r = {16'd1456,  7'd16};
            7'd46: r = {16'd1424,  7'd32};
            7'd47: r = {16'd1394,  7'd18};
            7'd48: r = {16'd1365,  7'd16};
            7'd49: r = {16'd1337,  7'd23};
            7'd50: r = {16'd1310,  7'd36};
            7'd51: r = {16'd1285,  7'd1};
            7'd52: r = {16'd1260,  7'd16};
            7'd53: r = {16'd1236,  7'd28};
            7'd54: r = {16'd1213,  7'd34};
            7'd55: r = {16'd1191,  7'd31};
            7'd56: r = {16'd1170,  7'd16};
            7'd57: r = {16'd1149,  7'd43};
            7'd58: r = {16'd1129,  7'd54};
            7'd59: r = {16'd1110,  7'd46};
            7'd60: r = {16'd1092,  7'd16};
            7'd61: r = {16'd1074,  7'd22};
            7'd62: r = {16'd1057,  7'd2};
            7'd63: r = {16'd1040,  7'd16};
            7'd64: r = {16'd1024,  7'd0};
            default: r = {16'd0, 7'd0};
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/bct_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bct_front
// Holds the segment count register, clamps it and packs each curve, with
// biased coordinates, into a queue entry.
// ----------------------------------------------------------------------------
module bct_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    input  wire logic [6:0]           i_cfg_data,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_mode,
    input  wire logic [15:0]          i_start_x,
    input  wire logic [15:0]          i_start_y,
    input  wire logic [15:0]          i_ctrl_a_x,
    input  wire logic [15:0]          i_ctrl_a_y,
    input  wire logic [15:0]          i_ctrl_b_x,
    input  wire logic [15:0]          i_ctrl_b_y,
    input  wire logic [15:0]          i_finish_x,
    input  wire logic [15:0]          i_finish_y,
    input  wire logic [31:0]          i_rgba_in,
    input  bct_pkg::t_queue_status    i_q_status,
    output logic                      o_push,
    output bct_pkg::t_curve           o_curve
);
    import bct_pkg::*;

    logic [6:0] r_seg_count;
    logic [6:0] seg_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_count <= SegCountReset;
        end else if (i_cfg_valid) begin
            r_seg_count <= i_cfg_data;
        end
    end

    always_comb begin
        if (r_seg_count == 7'd0) begin
            seg_n = 7'd1;
        end else if (r_seg_count > 7'(MaxSegments)) begin
            seg_n = 7'(MaxSegments);
        end else begin
            seg_n = r_seg_count;
        end
    end

    assign o_push = i_in_valid && !i_q_status.full;

    always_comb begin
        o_curve.cubic = i_mode;
        o_curve.seg_n = seg_n;
        o_curve.px[0] = i_start_x  ^ CoordBias;
        o_curve.px[1] = i_ctrl_a_x ^ CoordBias;
        o_curve.px[2] = i_ctrl_b_x ^ CoordBias;
        o_curve.px[3] = i_finish_x ^ CoordBias;
        o_curve.py[0] = i_start_y  ^ CoordBias;
        o_curve.py[1] = i_ctrl_a_y ^ CoordBias;
        o_curve.py[2] = i_ctrl_b_y ^ CoordBias;
        o_curve.py[3] = i_finish_y ^ CoordBias;
        o_curve.rgba  = i_rgba_in;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/bct_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bct_queue
// Two-entry curve queue between the front and the back.
// ----------------------------------------------------------------------------
module bct_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  bct_pkg::t_curve           i_curve,
    input  wire logic                 i_pop,
    output bct_pkg::t_curve           o_curve,
    output bct_pkg::t_queue_status    o_status
);
    import bct_pkg::*;

    t_curve     r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_curve = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_curve;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/bct_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bct_back
// Walks the segments of one curve: steps t, forms the Bernstein weights and
// the weighted sums on one shared multiplier, and drives the output register.
// ----------------------------------------------------------------------------
module bct_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  bct_pkg::t_curve           i_curve,
    input  bct_pkg::t_queue_status    i_q_status,
    output logic                      o_pop,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [15:0]               o_seg_start_x,
    output logic [15:0]               o_seg_start_y,
    output logic [15:0]               o_seg_end_x,
    output logic [15:0]               o_seg_end_y,
    output logic [31:0]               o_rgba_out,
    output logic                      o_last_segment
);
    import bct_pkg::*;

    t_back_state       r_state, n_state;
    t_curve            r_cur, n_cur;
    logic [6:0]        r_idx, n_idx;
    logic [15:0]       r_t, n_t;
    logic [6:0]        r_rem, n_rem;
    logic [4:0]        r_k, n_k;
    logic [15:0]       r_prev_x, n_prev_x;
    logic [15:0]       r_prev_y, n_prev_y;
    logic [15:0]       r_next_x, n_next_x;
    logic [15:0]       r_next_y, n_next_y;
    logic [32:0]       r_u2, n_u2;
    logic [31:0]       r_t2, n_t2;
    logic [3:0][48:0]  r_w, n_w;
    logic [63:0]       r_acc, n_acc;
    logic [51:0]       r_prod;
    logic              r_out_valid, n_out_valid;
    logic [15:0]       r_o_sx, n_o_sx;
    logic [15:0]       r_o_sy, n_o_sy;
    logic [15:0]       r_o_ex, n_o_ex;
    logic [15:0]       r_o_ey, n_o_ey;
    logic [31:0]       r_o_rgba, n_o_rgba;
    logic              r_o_last, n_o_last;

    logic [16:0] u_val;
    logic [34:0] mul_a;
    logic [16:0] mul_b;
    logic [4:0]  mac_j;
    logic [4:0]  acc_j;
    logic [63:0] shifted;
    logic [63:0] acc_sum;
    logic [64:0] rnd_sum;
    logic [16:0] rnd_q;
    logic [15:0] coord;
    logic [22:0] frac_load;
    logic [22:0] frac_cur;
    logic [6:0]  rem_sum;
    logic        out_free;
    logic        is_last;

    assign u_val = 17'h10000 - {1'b0, r_t};
    assign mac_j = r_k - 5'd7;
    assign acc_j = r_k - 5'd8;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_k)
            5'd0: begin
                mul_a = {18'd0, u_val};
                mul_b = u_val;
            end
            5'd1: begin
                mul_a = {19'd0, r_t};
                mul_b = {1'b0, r_t};
            end
            5'd2: begin
                mul_a = {18'd0, u_val};
                mul_b = {1'b0, r_t};
            end
            5'd3: begin
                mul_a = {2'd0, r_u2};
                mul_b = u_val;
            end
            5'd4: begin
                mul_a = {2'd0, r_u2};
                mul_b = {1'b0, r_t};
            end
            5'd5: begin
                mul_a = {3'd0, r_t2};
                mul_b = u_val;
            end
            5'd6: begin
                mul_a = {3'd0, r_t2};
                mul_b = {1'b0, r_t};
            end
            default: begin
                if (mac_j[0]) begin
                    mul_a = {11'd0, r_w[mac_j[2:1]][48:25]};
                end else begin
                    mul_a = {10'd0, r_w[mac_j[2:1]][24:0]};
                end
                if (mac_j[3]) begin
                    mul_b = {1'b0, r_cur.py[mac_j[2:1]]};
                end else begin
                    mul_b = {1'b0, r_cur.px[mac_j[2:1]]};
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= {17'd0, mul_a} * {35'd0, mul_b};
    end

    always_comb begin
        if (acc_j[0]) begin
            shifted = {r_prod[38:0], 25'd0};
        end else begin
            shifted = {12'd0, r_prod};
        end
        acc_sum = ((acc_j[2:0] == 3'd0) ? 64'd0 : r_acc) + shifted;
        rnd_sum = {1'b0, acc_sum} + {17'd0, 1'b1, 47'd0};
        rnd_q   = rnd_sum[64:48];
        coord   = (rnd_q[16] ? 16'hFFFF : rnd_q[15:0]) ^ CoordBias;
    end

    assign frac_load = step_frac(i_curve.seg_n);
    assign frac_cur  = step_frac(r_cur.seg_n);
    assign rem_sum   = r_rem + frac_cur[6:0];
    assign out_free  = !r_out_valid || !i_out_stall;
    assign is_last   = ({1'b0, r_idx} + 8'd1) == {1'b0, r_cur.seg_n};

    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_idx       = r_idx;
        n_t         = r_t;
        n_rem       = r_rem;
        n_k         = r_k;
        n_prev_x    = r_prev_x;
        n_prev_y    = r_prev_y;
        n_next_x    = r_next_x;
        n_next_y    = r_next_y;
        n_u2        = r_u2;
        n_t2        = r_t2;
        n_w         = r_w;
        n_acc       = r_acc;
        n_out_valid = r_out_valid && i_out_stall;
        n_o_sx      = r_o_sx;
        n_o_sy      = r_o_sy;
        n_o_ex      = r_o_ex;
        n_o_ey      = r_o_ey;
        n_o_rgba    = r_o_rgba;
        n_o_last    = r_o_last;
        o_pop       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop    = 1'b1;
                    n_cur    = i_curve;
                    n_idx    = 7'd0;
                    n_t      = frac_load[22:7];
                    n_rem    = frac_load[6:0];
                    n_prev_x = i_curve.px[0] ^ CoordBias;
                    n_prev_y = i_curve.py[0] ^ CoordBias;
                    n_k      = 5'd0;
                    if (i_curve.seg_n == 7'd1) begin
                        n_next_x = i_curve.px[3] ^ CoordBias;
                        n_next_y = i_curve.py[3] ^ CoordBias;
                        n_state  = ST_EMIT;
                    end else begin
                        n_state  = ST_CALC;
                    end
                end
            end
            ST_CALC: begin
                n_k = r_k + 5'd1;
                case (r_k)
                    5'd1: begin
                        n_u2 = r_prod[32:0];
                        if (!r_cur.cubic) begin
                            n_w[0] = {r_prod[32:0], 16'd0};
                        end
                    end
                    5'd2: begin
                        n_t2 = r_prod[31:0];
                        if (!r_cur.cubic) begin
                            n_w[3] = {r_prod[32:0], 16'd0};
                        end
                    end
                    5'd3: begin
                        if (!r_cur.cubic) begin
                            n_w[1] = {r_prod[31:0], 17'd0};
                            n_w[2] = '0;
                        end
                    end
                    5'd4: begin
                        if (r_cur.cubic) begin
                            n_w[0] = r_prod[48:0];
                        end
                    end
                    5'd5: begin
                        if (r_cur.cubic) begin
                            n_w[1] = r_prod[48:0] + {r_prod[47:0], 1'b0};
                        end
                    end
                    5'd6: begin
                        if (r_cur.cubic) begin
                            n_w[2] = r_prod[48:0] + {r_prod[47:0], 1'b0};
                        end
                    end
                    5'd7: begin
                        if (r_cur.cubic) begin
                            n_w[3] = r_prod[48:0];
                        end
                    end
                    default: begin
                        if (r_k >= 5'd8) begin
                            n_acc = acc_sum;
                            if (acc_j[3:0] == 4'd7) begin
                                n_next_x = coord;
                            end
                            if (acc_j[3:0] == 4'd15) begin
                                n_next_y = coord;
                                n_state  = ST_EMIT;
                            end
                        end
                    end
                endcase
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_sx      = r_prev_x;
                    n_o_sy      = r_prev_y;
                    n_o_ex      = r_next_x;
                    n_o_ey      = r_next_y;
                    n_o_rgba    = r_cur.rgba;
                    n_o_last    = is_last;
                    n_prev_x    = r_next_x;
                    n_prev_y    = r_next_y;
                    if (is_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx + 7'd1;
                        if (rem_sum >= r_cur.seg_n) begin
                            n_rem = rem_sum - r_cur.seg_n;
                            n_t   = r_t + frac_cur[22:7] + 16'd1;
                        end else begin
                            n_rem = rem_sum;
                            n_t   = r_t + frac_cur[22:7];
                        end
                        n_k = 5'd0;
                        if (({1'b0, r_idx} + 8'd2) == {1'b0, r_cur.seg_n}) begin
                            n_next_x = r_cur.px[3] ^ CoordBias;
                            n_next_y = r_cur.py[3] ^ CoordBias;
                        end else begin
                            n_state = ST_CALC;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_idx       <= 7'd0;
            r_k         <= 5'd0;
            r_prev_x    <= 16'd0;
            r_prev_y    <= 16'd0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
            r_k         <= n_k;
            r_prev_x    <= n_prev_x;
            r_prev_y    <= n_prev_y;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_t      <= n_t;
        r_rem    <= n_rem;
        r_next_x <= n_next_x;
        r_next_y <= n_next_y;
        r_u2     <= n_u2;
        r_t2     <= n_t2;
        r_w      <= n_w;
        r_acc    <= n_acc;
        r_o_sx   <= n_o_sx;
        r_o_sy   <= n_o_sy;
        r_o_ex   <= n_o_ex;
        r_o_ey   <= n_o_ey;
        r_o_rgba <= n_o_rgba;
        r_o_last <= n_o_last;
    end

    assign o_out_valid    = r_out_valid;
    assign o_seg_start_x  = r_o_sx;
    assign o_seg_start_y  = r_o_sy;
    assign o_seg_end_x    = r_o_ex;
    assign o_seg_end_y    = r_o_ey;
    assign o_rgba_out     = r_o_rgba;
    assign o_last_segment = r_o_last;

endmodule
`default_nettype wire

// ===== hw/rtl/bezier_curve_tessellator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Each computed segment uses the one shared multiplier to form 7 weight
// products and 16 partial products per point; the final segment of a curve
// takes the curve's end point and needs no products. The back takes the next
// curve from the queue only after the last segment of the current one has
// been emitted.
// Reset: synchronous, active low; clears control state, segment count to 16.
// ----------------------------------------------------------------------------
// bezier_curve_tessellator_core
// Splits quadratic and cubic curves into line segments at uniform t steps.
// ----------------------------------------------------------------------------
module bezier_curve_tessellator_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [6:0]         i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_mode,
    input  wire logic signed [15:0] i_start_x,
    input  wire logic signed [15:0] i_start_y,
    input  wire logic signed [15:0] i_ctrl_a_x,
    input  wire logic signed [15:0] i_ctrl_a_y,
    input  wire logic signed [15:0] i_ctrl_b_x,
    input  wire logic signed [15:0] i_ctrl_b_y,
    input  wire logic signed [15:0] i_finish_x,
    input  wire logic signed [15:0] i_finish_y,
    input  wire logic [31:0]        i_rgba_in,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [15:0]      o_seg_start_x,
    output logic signed [15:0]      o_seg_start_y,
    output logic signed [15:0]      o_seg_end_x,
    output logic signed [15:0]      o_seg_end_y,
    output logic [31:0]             o_rgba_out,
    output logic                    o_last_segment
);
    import bct_pkg::*;

    t_curve        push_curve;
    t_curve        head_curve;
    t_queue_status q_status;
    logic          push;
    logic          pop;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_status.full;

    bct_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_mode      (i_mode),
        .i_start_x   (i_start_x),
        .i_start_y   (i_start_y),
        .i_ctrl_a_x  (i_ctrl_a_x),
        .i_ctrl_a_y  (i_ctrl_a_y),
        .i_ctrl_b_x  (i_ctrl_b_x),
        .i_ctrl_b_y  (i_ctrl_b_y),
        .i_finish_x  (i_finish_x),
        .i_finish_y  (i_finish_y),
        .i_rgba_in   (i_rgba_in),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_curve     (push_curve)
    );

    bct_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_curve  (push_curve),
        .i_pop    (pop),
        .o_curve  (head_curve),
        .o_status (q_status)
    );

    bct_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_curve        (head_curve),
        .i_q_status     (q_status),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_seg_start_x  (o_seg_start_x),
        .o_seg_start_y  (o_seg_start_y),
        .o_seg_end_x    (o_seg_end_x),
        .o_seg_end_y    (o_seg_end_y),
        .o_rgba_out     (o_rgba_out),
        .o_last_segment (o_last_segment)
    );

endmodule
`default_nettype wire

// ===== tb/bezier_curve_tessellator_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezier_curve_tessellator_core_tb
// Feeds quadratic and cubic curves through the tessellator under several
// segment counts and idle patterns, predicts every line segment in fixed
// point and compares each transferred segment field by field, in order.
// ----------------------------------------------------------------------------
module bezier_curve_tessellator_core_tb;
    import bct_pkg::*;

    typedef struct packed {
        logic               cubic;
        logic signed [15:0] sx, sy, ax, ay, bx, by, fx, fy;
        logic [31:0]        rgba;
    } t_bezier;

    typedef struct packed {
        logic signed [15:0] sx, sy, ex, ey;
        logic [31:0]        rgba;
        logic               last;
    } t_segment;

    localparam int unsigned CycleLimit = 2000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [6:0]  i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        i_mode = 1'b0;
    logic signed [15:0] i_start_x = '0, i_start_y = '0, i_ctrl_a_x = '0, i_ctrl_a_y = '0;
    logic signed [15:0] i_ctrl_b_x = '0, i_ctrl_b_y = '0, i_finish_x = '0, i_finish_y = '0;
    logic [31:0] i_rgba_in = '0;
    logic        i_out_stall = 1'b0;
    logic        o_cfg_ready, o_in_stall, o_out_valid, o_last_segment;
    logic signed [15:0] o_seg_start_x, o_seg_start_y, o_seg_end_x, o_seg_end_y;
    logic [31:0] o_rgba_out;

    bezier_curve_tessellator_core dut (.*);

    initial forever #5 i_clk = ~i_clk;

    t_segment    pending_segs[$];
    logic [6:0]  seg_count_reg = SegCountReset;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned mismatches = 0;
    int unsigned cycles = 0;

    function automatic logic [15:0] blend_coord(input logic [63:0] w[4],
                                                input logic [15:0] p[4], input int cnt);
        logic [63:0] acc;
        acc = 0;
        for (int k = 0; k < cnt; k++) acc += w[k] * 64'(p[k] ^ CoordBias);
        acc = (acc + (64'd1 << 47)) >> 48;
        if (acc > 64'hFFFF) acc = 64'hFFFF;
        return acc[15:0] ^ CoordBias;
    endfunction

    task automatic predict_segments(input t_bezier c);
        int unsigned n;
        logic [63:0] t, u;
        logic [63:0] w[4];
        logic [15:0] qx[4], qy[4];
        logic [15:0] px, py, nx, ny;
        t_segment s;
        n = seg_count_reg;
        if (n == 0) n = 1;
        if (n > MaxSegments) n = MaxSegments;
        px = c.sx; py = c.sy;
        for (int i = 0; i < n; i++) begin
            if (i + 1 == n) begin
                nx = c.fx; ny = c.fy;
            end else begin
                t = (64'(i + 1) << 16) / n;
                u = 65536 - t;
                if (c.cubic) begin
                    w[0] = u * u * u; w[1] = 3 * u * u * t; w[2] = 3 * u * t * t; w[3] = t * t * t;
                    qx = '{c.sx, c.ax, c.bx, c.fx}; qy = '{c.sy, c.ay, c.by, c.fy};
                    nx = blend_coord(w, qx, 4); ny = blend_coord(w, qy, 4);
                end else begin
                    w[0] = (u * u) << 16; w[1] = (2 * u * t) << 16; w[2] = (t * t) << 16;
                    w[3] = 0;
                    qx = '{c.sx, c.ax, c.fx, 16'd0}; qy = '{c.sy, c.ay, c.fy, 16'd0};
                    nx = blend_coord(w, qx, 3); ny = blend_coord(w, qy, 3);
                end
            end
            s = '{px, py, nx, ny, c.rgba, (i + 1 == n)};
            pending_segs.push_back(s);
            px = nx; py = ny;
        end
    endtask

    // valid stays high after a transfer; the idle loop or a drain drops it
    task automatic send_curve(input t_bezier c);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode <= c.cubic;
        i_start_x <= c.sx; i_start_y <= c.sy;
        i_ctrl_a_x <= c.ax; i_ctrl_a_y <= c.ay;
        i_ctrl_b_x <= c.bx; i_ctrl_b_y <= c.by;
        i_finish_x <= c.fx; i_finish_y <= c.fy;
        i_rgba_in <= c.rgba;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_segments(c);
    endtask

    task automatic drain_and_settle();
        i_in_valid <= 1'b0;
        while (pending_segs.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_seg_count(input logic [6:0] v);
        drain_and_settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        seg_count_reg = v;
    endtask

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'(signed'($urandom_range(64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_bezier rand_curve();
        t_bezier c;
        c.cubic = $urandom_range(1);
        c.sx = rand_coord(); c.sy = rand_coord();
        c.ax = rand_coord(); c.ay = rand_coord();
        c.bx = rand_coord(); c.by = rand_coord();
        c.fx = rand_coord(); c.fy = rand_coord();
        c.rgba = $urandom;
        return c;
    endfunction

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        t_segment e, a;
        cycles <= cycles + 1;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            a = '{o_seg_start_x, o_seg_start_y, o_seg_end_x, o_seg_end_y,
                  o_rgba_out, o_last_segment};
            if (pending_segs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected segment %p", a);
            end else begin
                e = pending_segs.pop_front();
                if (a !== e) begin
                    mismatches++;
                    if (mismatches <= 10) $display("segment mismatch: exp %p got %p", e, a);
                end
            end
        end
        if (cycles > CycleLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic test_directed();
        t_bezier c;
        c = '{1'b0, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh1234, 16'sh4321,
              16'sh8000, 16'sh7FFF, 32'hFFFF_FFFF};
        send_curve(c);
        c = '{1'b1, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000,
              16'sh8000, 16'sh7FFF, 32'h0000_0000};
        send_curve(c);
        c = '{1'b1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
              16'sh7FFF, 16'sh7FFF, 32'hA5A5_5A5A};
        send_curve(c);
        c = '{1'b1, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
              16'sh8000, 16'sh8000, 32'h5A5A_A5A5};
        send_curve(c);
        c = '{1'b0, 16'sh0010, -16'sh0010, 16'sh0000, 16'sh0000, 16'shFFFF, 16'sh0001,
              -16'sh0001, 16'sh0001, 32'h1234_5678};
        send_curve(c);
        for (int i = 0; i < 4; i++) send_curve(rand_curve());
    endtask

    task automatic test_seg_count_extremes();
        logic [6:0] counts[6] = '{7'd0, 7'd1, 7'd64, 7'd65, 7'd127, 7'd2};
        foreach (counts[k]) begin
            write_seg_count(counts[k]);
            send_curve(rand_curve());
            send_curve(rand_curve());
        end
    endtask

    task automatic test_random_phases();
        int unsigned idle_pct[4] = '{0, 46, 0, 15};
        int unsigned st_pct[4]   = '{0, 0, 46, 15};
        for (int ph = 0; ph < 4; ph++) begin
            write_seg_count(7'($urandom_range(1, 12)));
            send_idle_pct = idle_pct[ph];
            stall_pct = st_pct[ph];
            for (int i = 0; i < 60; i++) begin
                if (i % 20 == 19) write_seg_count(7'($urandom_range(1, 20)));
                send_curve(rand_curve());
            end
            if (ph == 1) drain_and_settle();
        end
        send_idle_pct = 0;
        stall_pct = 0;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_seg_count_extremes();
        test_random_phases();
        write_seg_count(7'd16);
        send_curve(rand_curve());
        drain_and_settle();
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
